// File: design/dgsp_pkg.sv
// Package for the dual gauge stepper positioner: plan segment codes,
// phase pattern tables, cycle constants and the result word type.
// No dependencies.
package dgsp_pkg;

	// plan segment codes
	localparam logic [2:0] SEG_IDLE          = 3'd0;
	localparam logic [2:0] SEG_SU_HOME_FUEL  = 3'd1;
	localparam logic [2:0] SEG_SU_HOME_SPEED = 3'd2;
	localparam logic [2:0] SEG_SU_FIX_FUEL   = 3'd3;
	localparam logic [2:0] SEG_SU_FIX_SPEED  = 3'd4;
	localparam logic [2:0] SEG_HOME          = 3'd5;
	localparam logic [2:0] SEG_FIX           = 3'd6;
	localparam logic [2:0] SEG_MOVE          = 3'd7;

	// gauge select
	localparam logic GAUGE_SPEED = 1'b0;
	localparam logic GAUGE_FUEL  = 1'b1;

	// needle range and move limits
	localparam logic [6:0] POS_MAX       = 7'd100;
	localparam logic [6:0] FAR_MOVE      = 7'd60;
	localparam logic [6:0] DIR_SPLIT     = 7'd50;
	localparam logic [2:0] LAST_PHASE    = 3'd6;

	// fixed cycle counts
	localparam logic [8:0] SU_FUEL_CYC   = 9'd45;
	localparam logic [8:0] SU_SPEED_CYC  = 9'd37;
	localparam logic [8:0] SPD_B_CYC     = 9'd45;
	localparam logic [8:0] SPD_A_CYC     = 9'd48;
	localparam logic [8:0] FUEL_B_CYC    = 9'd46;
	localparam logic [8:0] FUEL_A_CYC    = 9'd45;

	// result word of one item
	typedef struct packed {
		logic [7:0] coils;
		logic       busy;
		logic       accepted;
		logic [6:0] speed_pos;
		logic [6:0] fuel_pos;
	} result_t;

	// coil pattern for a sequence and phase
	function automatic logic [3:0] seq_pat(input logic dir, input logic [2:0] ph);
		logic [3:0] p;
		if (!dir) begin
			case (ph)
				3'd0: p = 4'h1;
				3'd1: p = 4'h3;
				3'd2: p = 4'h2;
				3'd3: p = 4'h6;
				3'd4: p = 4'h4;
				3'd5: p = 4'hC;
				3'd6: p = 4'h8;
				default: p = 4'h9;
			endcase
		end else begin
			case (ph)
				3'd0: p = 4'h9;
				3'd1: p = 4'h8;
				3'd2: p = 4'hC;
				3'd3: p = 4'h4;
				3'd4: p = 4'h6;
				3'd5: p = 4'h2;
				3'd6: p = 4'h3;
				default: p = 4'h1;
			endcase
		end
		return p;
	endfunction

	// distance to cycles with per-gauge compensation
	function automatic logic [8:0] comp_cycles(input logic g, input logic [6:0] d);
		logic [6:0] e;
		e = d;
		if (g == GAUGE_SPEED) begin
			if (d > 7'd50)
				e = d + 7'd4;
			else if (d >= 7'd40)
				e = d + 7'd3;
			else if (d >= 7'd20)
				e = d + 7'd2;
			else if (d != 7'd0)
				e = d + 7'd1;
		end else begin
			if (d > 7'd40)
				e = d + 7'd3;
			else if (d >= 7'd15)
				e = d + 7'd2;
			else if (d >= 7'd10)
				e = d + 7'd1;
		end
		return {e, 2'b00};
	endfunction

	// fixed run after homing, per gauge and sequence
	function automatic logic [8:0] fix_cycles(input logic g, input logic dir);
		logic [8:0] c;
		if (g == GAUGE_SPEED)
			c = dir ? SPD_B_CYC : SPD_A_CYC;
		else
			c = dir ? FUEL_B_CYC : FUEL_A_CYC;
		return c;
	endfunction

endpackage

// File: design/dgsp_plan.sv
// Plan state and single-pass update for one word: tick stepping with
// segment hand-over, and target command intake. Uses dgsp_pkg.
module dgsp_plan import dgsp_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          fire,
	input  logic          op,
	input  logic          gauge,
	input  logic [6:0]    target,
	input  logic [1:0]    home_sensors,
	output result_t       res
);

	logic [6:0] speed_pos_q, fuel_pos_q;
	logic [2:0] seg_q, phase_q;
	logic       gauge_q, dir_q;
	logic [8:0] cyc_q, final_q;
	logic [7:0] coil_q;

	logic [6:0] speed_pos_d, fuel_pos_d;
	logic [2:0] seg_d, phase_d;
	logic       gauge_d, dir_d;
	logic [8:0] cyc_d, final_d;
	logic [7:0] coil_d;
	logic       acc_d;

	// next state for one word
	always_comb begin
		logic       homing;
		logic       done;
		logic [6:0] t, cur, span, fin_d;
		logic [3:0] pat;
		logic [8:0] cc;
		speed_pos_d = speed_pos_q;
		fuel_pos_d  = fuel_pos_q;
		seg_d       = seg_q;
		phase_d     = phase_q;
		gauge_d     = gauge_q;
		dir_d       = dir_q;
		cyc_d       = cyc_q;
		final_d     = final_q;
		coil_d      = coil_q;
		acc_d       = 1'b0;
		homing      = 1'b0;
		done        = 1'b0;
		pat         = 4'h0;
		t           = (target > POS_MAX) ? POS_MAX : target;
		cur         = (gauge == GAUGE_SPEED) ? speed_pos_q : fuel_pos_q;
		span        = (t < cur) ? (cur - t) : (t - cur);
		fin_d       = 7'd0;
		cc          = 9'd0;
		if (!op) begin
			// finished segments hand over within the tick
			for (int i = 0; i < 3; i++) begin
				homing = (seg_d == SEG_SU_HOME_FUEL) || (seg_d == SEG_SU_HOME_SPEED) ||
					(seg_d == SEG_HOME);
				if (homing)
					done = (gauge_d == GAUGE_FUEL) ? home_sensors[0] : home_sensors[1];
				else
					done = (cyc_d == 9'd0);
				if (seg_d != SEG_IDLE && phase_d == 3'd0 && done) begin
					phase_d = 3'd0;
					case (seg_d)
						SEG_SU_HOME_FUEL: begin
							seg_d   = SEG_SU_HOME_SPEED;
							gauge_d = GAUGE_SPEED;
							dir_d   = 1'b0;
						end
						SEG_SU_HOME_SPEED: begin
							seg_d   = SEG_SU_FIX_FUEL;
							gauge_d = GAUGE_FUEL;
							dir_d   = 1'b0;
							cyc_d   = SU_FUEL_CYC;
						end
						SEG_SU_FIX_FUEL: begin
							seg_d   = SEG_SU_FIX_SPEED;
							gauge_d = GAUGE_SPEED;
							dir_d   = 1'b1;
							cyc_d   = SU_SPEED_CYC;
						end
						SEG_HOME: begin
							seg_d = SEG_FIX;
							cyc_d = fix_cycles(gauge_d, dir_d);
						end
						SEG_FIX: begin
							seg_d = SEG_MOVE;
							cyc_d = final_q;
						end
						default: seg_d = SEG_IDLE;
					endcase
				end
			end
			// emit one pattern if a segment still runs
			if (seg_d != SEG_IDLE) begin
				homing = (seg_d == SEG_SU_HOME_FUEL) || (seg_d == SEG_SU_HOME_SPEED) ||
					(seg_d == SEG_HOME);
				pat    = seq_pat(dir_d, phase_d);
				coil_d = (gauge_d == GAUGE_SPEED) ? {pat, 4'h0} : {4'h0, pat};
				if (phase_d == LAST_PHASE) begin
					phase_d = 3'd0;
					if (!homing && cyc_d != 9'd0)
						cyc_d = cyc_d - 9'd1;
				end else begin
					phase_d = phase_d + 3'd1;
				end
			end
		end else if (seg_q == SEG_IDLE) begin
			// target command
			acc_d   = 1'b1;
			gauge_d = gauge;
			phase_d = 3'd0;
			if (span > FAR_MOVE) begin
				dir_d   = (cur > DIR_SPLIT);
				fin_d   = (cur > DIR_SPLIT) ? t : (POS_MAX - t);
				final_d = comp_cycles(gauge, fin_d);
				cyc_d   = 9'd0;
				seg_d   = SEG_HOME;
			end else begin
				dir_d = (t >= cur);
				cc    = comp_cycles(gauge, span);
				cyc_d = cc;
				seg_d = (cc != 9'd0) ? SEG_MOVE : SEG_IDLE;
			end
			if (gauge == GAUGE_SPEED)
				speed_pos_d = t;
			else
				fuel_pos_d = t;
		end
	end

	// plan registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_pos_q <= 7'd0;
			fuel_pos_q  <= POS_MAX;
			seg_q       <= SEG_SU_HOME_FUEL;
			phase_q     <= 3'd0;
			gauge_q     <= GAUGE_FUEL;
			dir_q       <= 1'b0;
			cyc_q       <= 9'd0;
			final_q     <= 9'd0;
			coil_q      <= 8'd0;
		end else if (fire) begin
			speed_pos_q <= speed_pos_d;
			fuel_pos_q  <= fuel_pos_d;
			seg_q       <= seg_d;
			phase_q     <= phase_d;
			gauge_q     <= gauge_d;
			dir_q       <= dir_d;
			cyc_q       <= cyc_d;
			final_q     <= final_d;
			coil_q      <= coil_d;
		end
	end

	// result word after this item
	assign res.coils     = coil_d;
	assign res.busy      = (seg_d != SEG_IDLE);
	assign res.accepted  = acc_d;
	assign res.speed_pos = speed_pos_d;
	assign res.fuel_pos  = fuel_pos_d;

endmodule

// File: design/dual_gauge_stepper_positioner.sv
// Dual gauge stepper positioner, top level: input register, plan update, result register.
// Each word is registered at the input, then its result word is held in the result register.
// Throughput: one word per cycle unless res_stall holds it; single-pass plan update per word.
// Reset (arst_n low) empties both registers and starts the start-up homing plan.
// Uses dgsp_pkg and dgsp_plan.
module dual_gauge_stepper_positioner import dgsp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cmd_valid,
	output logic       cmd_stall,
	input  logic       op,
	input  logic       gauge,
	input  logic [6:0] target,
	input  logic [1:0] home_sensors,
	output logic       res_valid,
	input  logic       res_stall,
	output logic [7:0] coils,
	output logic       busy_res,
	output logic       accepted,
	output logic [6:0] speed_position,
	output logic [6:0] fuel_position
);

	logic       valid_s1;
	logic       op_s1, gauge_s1;
	logic [6:0] target_s1;
	logic [1:0] sens_s1;
	logic       fire;
	result_t    res;
	result_t    res_q;
	logic       res_valid_q;

	// word moves from input register to result register
	assign fire      = valid_s1 && (!res_valid_q || !res_stall);
	assign cmd_stall = valid_s1 && !fire;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (!cmd_stall)
			valid_s1 <= cmd_valid;
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && !cmd_stall) begin
			op_s1     <= op;
			gauge_s1  <= gauge;
			target_s1 <= target;
			sens_s1   <= home_sensors;
		end
	end

	dgsp_plan u_plan (
		.clk          (clk),
		.arst_n       (arst_n),
		.fire         (fire),
		.op           (op_s1),
		.gauge        (gauge_s1),
		.target       (target_s1),
		.home_sensors (sens_s1),
		.res          (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else if (fire)
			res_valid_q <= 1'b1;
		else if (!res_stall)
			res_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (fire)
			res_q <= res;
	end

	assign res_valid      = res_valid_q;
	assign coils          = res_q.coils;
	assign busy_res       = res_q.busy;
	assign accepted       = res_q.accepted;
	assign speed_position = res_q.speed_pos;
	assign fuel_position  = res_q.fuel_pos;

endmodule

// File: sim/dual_gauge_stepper_positioner_tb.sv
`timescale 1ns / 100ps
// Testbench for dual_gauge_stepper_positioner: a directed script, then random traffic,
// every result word checked against a script word or an in-bench model of the two needle plans.
// Depends on dgsp_pkg and the positioner RTL.
module dual_gauge_stepper_positioner_tb;
	import dgsp_pkg::*;

	localparam logic OP_TICK   = 1'b0;
	localparam logic OP_TARGET = 1'b1;
	localparam int   UNTIL_IDLE = 0;
	localparam int   RAND_WORDS = 2000;
	// phase patterns, phase 0 in the low nibble
	localparam logic [31:0] SEQ_A_PATS = 32'h98C46231;
	localparam logic [31:0] SEQ_B_PATS = 32'h13264C89;

	typedef struct packed {
		logic       op;
		logic       g;
		logic [6:0] t;
		logic [1:0] s;
		int         reps;
		logic       typed;
		result_t    want;
	} drive_row_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cmd_valid = 1'b0;
	logic       cmd_stall;
	logic       op = 1'b0;
	logic       gauge = 1'b0;
	logic [6:0] target = '0;
	logic [1:0] home_sensors = '0;
	logic       res_valid;
	logic       res_stall = 1'b0;
	logic [7:0] coils;
	logic       busy_res;
	logic       accepted;
	logic [6:0] speed_position;
	logic [6:0] fuel_position;

	// needle plan model state, at its reset values
	logic [6:0] speed_at = 7'd0;
	logic [6:0] fuel_at = 7'd100;
	logic [2:0] plan_seg = SEG_SU_HOME_FUEL;
	logic       move_gauge = GAUGE_FUEL;
	logic       seq_b = 1'b0;
	logic [2:0] phase_no = 3'd0;
	logic [8:0] run_left = 9'd0;
	logic [8:0] final_run = 9'd0;
	logic [7:0] coil_now = 8'd0;

	result_t    needle_reports[$];
	drive_row_t script[$];
	int         faults = 0;
	int         burst_left = 0;
	int         words_seen = 0;
	int         hold_left = 0;
	bit         hold_done = 1'b0;
	int         stall_mode = 0;
	int         mode_left = 0;

	dual_gauge_stepper_positioner DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.op(op),
		.gauge(gauge),
		.target(target),
		.home_sensors(home_sensors),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.coils(coils),
		.busy_res(busy_res),
		.accepted(accepted),
		.speed_position(speed_position),
		.fuel_position(fuel_position)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// travel distance to coil cycles, with the per-gauge slack
	function automatic logic [8:0] cycles_for_travel(input logic g, input int d);
		int         e;
		logic [8:0] c;
		e = d;
		if (g == GAUGE_SPEED) begin
			if (d > 50)
				e = d + 4;
			else if (d >= 40)
				e = d + 3;
			else if (d >= 20)
				e = d + 2;
			else if (d != 0)
				e = d + 1;
		end else begin
			if (d > 40)
				e = d + 3;
			else if (d >= 15)
				e = d + 2;
			else if (d >= 10)
				e = d + 1;
		end
		c = 9'(4 * e);
		return c;
	endfunction

	function automatic logic homing_now();
		return plan_seg == SEG_SU_HOME_FUEL || plan_seg == SEG_SU_HOME_SPEED ||
			plan_seg == SEG_HOME;
	endfunction

	// hand over to the following plan segment
	task automatic next_segment();
		logic [2:0] nxt;
		case (plan_seg)
			SEG_SU_HOME_FUEL:  nxt = SEG_SU_HOME_SPEED;
			SEG_SU_HOME_SPEED: nxt = SEG_SU_FIX_FUEL;
			SEG_SU_FIX_FUEL:   nxt = SEG_SU_FIX_SPEED;
			SEG_HOME:          nxt = SEG_FIX;
			SEG_FIX:           nxt = SEG_MOVE;
			default:           nxt = SEG_IDLE;
		endcase
		plan_seg = nxt;
		phase_no = 3'd0;
		case (nxt)
			SEG_SU_HOME_SPEED: begin
				move_gauge = GAUGE_SPEED;
				seq_b = 1'b0;
			end
			SEG_SU_FIX_FUEL: begin
				move_gauge = GAUGE_FUEL;
				seq_b = 1'b0;
				run_left = SU_FUEL_CYC;
			end
			SEG_SU_FIX_SPEED: begin
				move_gauge = GAUGE_SPEED;
				seq_b = 1'b1;
				run_left = SU_SPEED_CYC;
			end
			SEG_FIX: begin
				if (move_gauge == GAUGE_SPEED)
					run_left = seq_b ? SPD_B_CYC : SPD_A_CYC;
				else
					run_left = seq_b ? FUEL_B_CYC : FUEL_A_CYC;
			end
			SEG_MOVE: run_left = final_run;
			default: ;
		endcase
	endtask

	// one timer tick: finished segments hand over, then at most one pattern
	task automatic tick_plan(input logic [1:0] s);
		logic       homing;
		logic       done;
		logic       emitted;
		logic [3:0] pat;
		int         guard;
		emitted = 1'b0;
		guard = 0;
		while (!emitted && plan_seg != SEG_IDLE && guard < 8) begin
			homing = homing_now();
			done = 1'b0;
			if (phase_no == 3'd0)
				done = homing ? s[move_gauge == GAUGE_FUEL ? 0 : 1] : (run_left == 9'd0);
			if (done) begin
				next_segment();
			end else begin
				pat = seq_b ? SEQ_B_PATS[{phase_no, 2'b00} +: 4] :
					SEQ_A_PATS[{phase_no, 2'b00} +: 4];
				coil_now = (move_gauge == GAUGE_SPEED) ? {pat, 4'h0} : {4'h0, pat};
				if (phase_no == LAST_PHASE) begin
					phase_no = 3'd0;
					if (!homing && run_left != 9'd0)
						run_left = run_left - 9'd1;
				end else begin
					phase_no = phase_no + 3'd1;
				end
				emitted = 1'b1;
			end
			guard++;
		end
	endtask

	// new target while idle; far moves go round through zero
	task automatic take_target(input logic g, input logic [6:0] t);
		int from;
		int span;
		from = (g == GAUGE_SPEED) ? int'(speed_at) : int'(fuel_at);
		span = (t < from) ? from - t : t - from;
		move_gauge = g;
		phase_no = 3'd0;
		if (span > FAR_MOVE) begin
			seq_b = from > DIR_SPLIT;
			final_run = cycles_for_travel(g, seq_b ? int'(t) : int'(POS_MAX - t));
			run_left = 9'd0;
			plan_seg = SEG_HOME;
		end else begin
			seq_b = t >= from;
			run_left = cycles_for_travel(g, span);
			plan_seg = (run_left != 9'd0) ? SEG_MOVE : SEG_IDLE;
		end
		if (g == GAUGE_SPEED)
			speed_at = t;
		else
			fuel_at = t;
	endtask

	task automatic step_gauges(input logic o, input logic g, input logic [6:0] t,
			input logic [1:0] s, output result_t r);
		logic took;
		took = 1'b0;
		if (o == OP_TICK) begin
			tick_plan(s);
		end else if (plan_seg == SEG_IDLE) begin
			take_target(g, (t > POS_MAX) ? POS_MAX : t);
			took = 1'b1;
		end
		r.coils = coil_now;
		r.busy = plan_seg != SEG_IDLE;
		r.accepted = took;
		r.speed_pos = speed_at;
		r.fuel_pos = fuel_at;
	endtask

	// offer one word in the current burst, book its result once taken
	task automatic offer_word(input logic o, input logic g, input logic [6:0] t,
			input logic [1:0] s, input logic typed, input result_t want);
		int      gap;
		result_t r;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 30);
			gap = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 8) : 0;
			if (gap != 0) begin
				cmd_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		op <= o;
		gauge <= g;
		target <= t;
		home_sensors <= s;
		cmd_valid <= 1'b1;
		do
			@(posedge clk);
		while (cmd_stall !== 1'b0);
		step_gauges(o, g, t, s, r);
		needle_reports.push_back(typed ? want : r);
	endtask

	task automatic add_row(input logic o, input logic g, input logic [6:0] t,
			input logic [1:0] s, input int reps, input logic typed, input result_t want);
		drive_row_t row;
		row.op = o;
		row.g = g;
		row.t = t;
		row.s = s;
		row.reps = reps;
		row.typed = typed;
		row.want = want;
		script.push_back(row);
	endtask

	task automatic check_field(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (got !== want) begin
			$display("%0t %s mismatch: expected %0d, got %0d", $time, name, want, got);
			faults++;
		end
	endtask

	// result side: check each taken word, then pick the next stall value
	always @(posedge clk) begin : result_side
		result_t want;
		bit      stall;
		if (arst_n && res_valid === 1'b1 && res_stall === 1'b0) begin
			if (needle_reports.size() == 0) begin
				$display("%0t result word with nothing expected", $time);
				faults++;
			end else begin
				want = needle_reports.pop_front();
				check_field("coils", want.coils, coils);
				check_field("busy_res", 8'(want.busy), 8'(busy_res));
				check_field("accepted", 8'(want.accepted), 8'(accepted));
				check_field("speed_position", 8'(want.speed_pos), 8'(speed_position));
				check_field("fuel_position", 8'(want.fuel_pos), 8'(fuel_position));
			end
			words_seen++;
		end
		if (mode_left == 0) begin
			stall_mode = $urandom_range(0, 2);
			mode_left = $urandom_range(20, 120);
		end
		mode_left--;
		// one long hold-off so the block backs up onto its input
		if (hold_left != 0) begin
			hold_left--;
			stall = 1'b1;
		end else if (!hold_done && words_seen >= 300) begin
			hold_done = 1'b1;
			hold_left = 200;
			stall = 1'b1;
		end else if (stall_mode == 1) begin
			stall = $urandom_range(0, 3) == 0;
		end else if (stall_mode == 2) begin
			stall = $urandom_range(0, 3) != 0;
		end else begin
			stall = 1'b0;
		end
		res_stall <= stall;
	end

	initial begin
		#10_000_000;
		$display("[dual_gauge_stepper_positioner] ERROR");
		$finish;
	end

	// stimulus
	initial begin
		drive_row_t row;
		int         i;
		int         counted;
		int         pos;
		int         d;
		int         r;
		int         tgt;
		logic       o;
		logic       g;
		logic       busy_now;
		logic [6:0] t;
		logic [1:0] s;

		// start-up homing, ignored command, idle tick
		add_row(OP_TICK, 1'b0, 7'd0, 2'd0, 1, 1'b1, {8'h01, 1'b1, 1'b0, 7'd0, 7'd100});
		add_row(OP_TARGET, 1'b0, 7'd50, 2'd0, 1, 1'b1, {8'h01, 1'b1, 1'b0, 7'd0, 7'd100});
		add_row(OP_TICK, 1'b1, 7'd100, 2'd2, 1, 1'b0, '0);
		add_row(OP_TICK, 1'b0, 7'd0, 2'd3, UNTIL_IDLE, 1'b0, '0);
		add_row(OP_TICK, 1'b1, 7'd127, 2'd0, 1, 1'b1, {8'h30, 1'b0, 1'b0, 7'd0, 7'd100});
		// zero-length moves, saturation, short move, command while moving
		add_row(OP_TARGET, 1'b0, 7'd0, 2'd3, 1, 1'b1, {8'h30, 1'b0, 1'b1, 7'd0, 7'd100});
		add_row(OP_TARGET, 1'b1, 7'd127, 2'd0, 1, 1'b1, {8'h30, 1'b0, 1'b1, 7'd0, 7'd100});
		add_row(OP_TARGET, 1'b0, 7'd1, 2'd0, 1, 1'b1, {8'h30, 1'b1, 1'b1, 7'd1, 7'd100});
		add_row(OP_TARGET, 1'b0, 7'd5, 2'd1, 1, 1'b1, {8'h30, 1'b1, 1'b0, 7'd1, 7'd100});
		add_row(OP_TICK, 1'b0, 7'd0, 2'd0, UNTIL_IDLE, 1'b0, '0);
		add_row(OP_TICK, 1'b1, 7'd64, 2'd3, 1, 1'b0, '0);
		// fuel round through zero, sensor late and on the wrong gauge first
		add_row(OP_TARGET, 1'b1, 7'd0, 2'd0, 1, 1'b0, '0);
		add_row(OP_TICK, 1'b0, 7'd0, 2'd0, 20, 1'b0, '0);
		add_row(OP_TICK, 1'b0, 7'd0, 2'd2, 10, 1'b0, '0);
		add_row(OP_TICK, 1'b0, 7'd0, 2'd1, UNTIL_IDLE, 1'b0, '0);
		// speed round through zero, then the longest direct move
		add_row(OP_TARGET, 1'b0, 7'd100, 2'd0, 1, 1'b0, '0);
		add_row(OP_TICK, 1'b0, 7'd0, 2'd3, UNTIL_IDLE, 1'b0, '0);
		add_row(OP_TARGET, 1'b0, 7'd40, 2'd3, 1, 1'b0, '0);
		add_row(OP_TICK, 1'b0, 7'd0, 2'd0, UNTIL_IDLE, 1'b0, '0);
		// just over the far limit, with a final move after the fixed run
		add_row(OP_TARGET, 1'b1, 7'd61, 2'd1, 1, 1'b0, '0);
		add_row(OP_TICK, 1'b0, 7'd0, 2'd0, 15, 1'b0, '0);
		add_row(OP_TICK, 1'b0, 7'd0, 2'd1, UNTIL_IDLE, 1'b0, '0);
		add_row(OP_TARGET, 1'b1, 7'd101, 2'd2, 1, 1'b0, '0);
		add_row(OP_TICK, 1'b1, 7'd127, 2'd3, UNTIL_IDLE, 1'b0, '0);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		for (i = 0; i < script.size(); i++) begin
			row = script[i];
			if (row.reps == UNTIL_IDLE) begin
				do
					offer_word(row.op, row.g, row.t, row.s, row.typed, row.want);
				while (plan_seg != SEG_IDLE);
			end else begin
				repeat (row.reps)
					offer_word(row.op, row.g, row.t, row.s, row.typed, row.want);
			end
		end

		// random traffic: mostly ticks while moving, short moves, few far ones
		counted = 0;
		while (counted < RAND_WORDS) begin
			busy_now = plan_seg != SEG_IDLE;
			if (busy_now)
				o = ($urandom_range(0, 19) == 0) ? OP_TARGET : OP_TICK;
			else
				o = ($urandom_range(0, 9) < 7) ? OP_TARGET : OP_TICK;
			g = 1'($urandom_range(0, 1));
			t = 7'($urandom_range(0, 127));
			s = 2'($urandom_range(0, 3));
			if (o == OP_TARGET && !busy_now) begin
				pos = (g == GAUGE_SPEED) ? int'(speed_at) : int'(fuel_at);
				r = $urandom_range(0, 99);
				d = 0;
				if (r < 45)
					d = $urandom_range(0, 3);
				else if (r < 75)
					d = $urandom_range(4, 14);
				else if (r < 90)
					d = $urandom_range(15, 60);
				if (r < 90) begin
					tgt = $urandom_range(0, 1) ? pos + d : pos - d;
					if (tgt > 100)
						tgt = pos - d;
					else if (tgt < 0)
						tgt = pos + d;
					if (tgt < 0)
						tgt = 0;
					else if (tgt > 100)
						tgt = 100;
				end else if (r < 96) begin
					tgt = $urandom_range(0, 127);
				end else if (pos >= 61) begin
					tgt = $urandom_range(0, pos - 61);
				end else if (pos <= 39) begin
					tgt = $urandom_range(pos + 61, 100);
				end else begin
					tgt = $urandom_range(0, 127);
				end
				t = 7'(tgt);
			end
			if (o == OP_TICK && homing_now())
				s[move_gauge == GAUGE_FUEL ? 0 : 1] = $urandom_range(0, 5) == 0;
			offer_word(o, g, t, s, 1'b0, '0);
			counted++;
		end
		cmd_valid <= 1'b0;

		// drain, then allow for the pipeline latency
		while (needle_reports.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (faults == 0)
			$display("[dual_gauge_stepper_positioner] OK");
		else
			$display("[dual_gauge_stepper_positioner] ERROR");
		$finish;
	end

endmodule
